@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the dispatcher datapath; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ design/tws_pkg.sv @@
// ----------------------------------------------------------------------------
// tws_pkg
// Sizes, codes and controller/datapath interface types of the dispatcher.
// ----------------------------------------------------------------------------
package tws_pkg;

  // sizing
  localparam int WORKERS     = 8;
  localparam int STACK_DEPTH = 256;
  localparam int WID_W       = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH   = WORKERS * STACK_DEPTH;
  localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // payload field widths
  localparam int MODE_W   = 2;
  localparam int WORKER_W = 3;
  localparam int TILE_W   = 10;
  localparam int ACCUM_W  = 16;
  localparam int TASK_W   = 2 * TILE_W + ACCUM_W;

  // input item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_REQ   = 2'd1,
    MODE_FRAME = 2'd2
  } mode_t;

  // source of the stack count address
  typedef enum logic [1:0] {
    CS_ITEM = 2'd0,
    CS_SCAN = 2'd1,
    CS_SRC  = 2'd2
  } cnt_sel_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SCAN   = 3'd2,
    S_PICK   = 3'd3,
    S_READ   = 3'd4,
    S_POP    = 3'd5,
    S_EXH    = 3'd6
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     do_clear;
    logic     do_push;
    logic     src_own;
    logic     scan_start;
    logic     scan_step;
    logic     src_best;
    logic     rd_pop;
    logic     out_task;
    logic     out_exh;
    cnt_sel_t cnt_sel;
  } tws_cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  worker_ok;
    logic  full;
    logic  told;
    logic  own_empty;
    logic  scan_last;
    logic  best_empty;
    logic  out_free;
  } tws_stat_t;

endpackage

@@ design/tile_work_stealing_dispatcher.sv @@
// ----------------------------------------------------------------------------
// tile_work_stealing_dispatcher
// Per-worker LIFO tile task stacks with stealing from the largest stack.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one item: push a task onto a
// worker's stack, request a task for a worker, or start a new frame.
// Output channel (out_valid / out_stall) carries one reply per serviced
// request: the task handed out, or an exhausted marker with frame_done set
// once every worker has been told there is no work.
// Items are handled one at a time. A push, a new frame or an ignored item
// passes through decode and back to idle before the next accept. A request
// served from the worker's own stack steps through decode, memory read, reply
// load and idle, the reply load writing the output register. A request that
// must steal adds the largest-stack scan and pick, which walks the stack
// counts through one count port, one worker per cycle; a request that finds
// no task anywhere goes from the pick to an exhausted step instead.
// The reply sits in an output register; the next item is accepted while it
// waits. If the receiver stalls and a new reply is ready, the sequencer holds
// in its pop or exhausted step and in_stall stays high until the register
// frees.
// Reset clears all stack counts, the exhausted flags and the output valid;
// stack memory contents are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
module tile_work_stealing_dispatcher
  import tws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [WORKER_W-1:0] in_worker,
  input  logic [TILE_W-1:0]   in_tile_x,
  input  logic [TILE_W-1:0]   in_tile_y,
  input  logic [ACCUM_W-1:0]  in_accum_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORKER_W-1:0] out_dest_worker,
  output logic [TILE_W-1:0]   out_task_x,
  output logic [TILE_W-1:0]   out_task_y,
  output logic [ACCUM_W-1:0]  out_task_accum,
  output logic                out_exhausted,
  output logic                out_frame_done
);

  tws_cmd_t  cmd;
  tws_stat_t stat;

  // sequencer
  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stacks, counts and result register
  tws_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_worker       (in_worker),
    .in_tile_x       (in_tile_x),
    .in_tile_y       (in_tile_y),
    .in_accum_id     (in_accum_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dest_worker (out_dest_worker),
    .out_task_x      (out_task_x),
    .out_task_y      (out_task_y),
    .out_task_accum  (out_task_accum),
    .out_exhausted   (out_exhausted),
    .out_frame_done  (out_frame_done)
  );

endmodule

@@ design/tws_ram.sv @@
// ----------------------------------------------------------------------------
// tws_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module tws_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/tws_ctrl.sv @@
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer of the dispatcher: decodes an item, runs the largest-stack scan,
// pops the stack memory and loads the result register.
// ----------------------------------------------------------------------------
module tws_ctrl
  import tws_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tws_stat_t stat,
  output tws_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   is_req;

  // request that actually gets serviced
  assign is_req = (stat.mode == MODE_REQ) && stat.worker_ok && !stat.told;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (is_req) begin
          state_nxt = stat.own_empty ? S_SCAN : S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = stat.best_empty ? S_EXH : S_READ;
      end
      S_READ: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_EXH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    cmd.cnt_sel = CS_ITEM;
    in_stall    = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      S_DECODE: begin
        cmd.do_clear   = (stat.mode == MODE_FRAME);
        cmd.do_push    = (stat.mode == MODE_PUSH) && stat.worker_ok && !stat.full;
        cmd.src_own    = is_req && !stat.own_empty;
        cmd.scan_start = is_req && stat.own_empty;
      end
      S_SCAN: begin
        cmd.cnt_sel   = CS_SCAN;
        cmd.scan_step = 1'b1;
      end
      S_PICK: begin
        cmd.src_best = !stat.best_empty;
      end
      S_READ: begin
        cmd.cnt_sel = CS_SRC;
        cmd.rd_pop  = 1'b1;
      end
      S_POP: begin
        cmd.out_task = stat.out_free;
      end
      S_EXH: begin
        cmd.out_exh = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/tws_datapath.sv @@
// ----------------------------------------------------------------------------
// tws_datapath
// Item register, stack counts, exhausted flags, scan registers, task stack
// memory and result register of the dispatcher.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tws_datapath
  import tws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  tws_cmd_t            cmd,
  output tws_stat_t           stat,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [WORKER_W-1:0] in_worker,
  input  logic [TILE_W-1:0]   in_tile_x,
  input  logic [TILE_W-1:0]   in_tile_y,
  input  logic [ACCUM_W-1:0]  in_accum_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORKER_W-1:0] out_dest_worker,
  output logic [TILE_W-1:0]   out_task_x,
  output logic [TILE_W-1:0]   out_task_y,
  output logic [ACCUM_W-1:0]  out_task_accum,
  output logic                out_exhausted,
  output logic                out_frame_done
);

  // item register
  logic [MODE_W-1:0]   item_mode_r;
  logic [WORKER_W-1:0] item_worker_r;
  logic [TILE_W-1:0]   item_x_r;
  logic [TILE_W-1:0]   item_y_r;
  logic [ACCUM_W-1:0]  item_acc_r;

  // stack bookkeeping
  logic [CNT_W-1:0]   cnt_r [WORKERS];
  logic [CNT_W-1:0]   cnt_nxt [WORKERS];
  logic [WORKERS-1:0] told_r, told_nxt;
  logic [WID_W-1:0]   src_r;
  logic [WID_W-1:0]   scan_idx_r;
  logic [WID_W-1:0]   best_idx_r;
  logic [CNT_W-1:0]   best_cnt_r;

  // result register
  logic                out_valid_r;
  logic [WORKER_W-1:0] out_dest_r;
  logic [TILE_W-1:0]   out_x_r;
  logic [TILE_W-1:0]   out_y_r;
  logic [ACCUM_W-1:0]  out_acc_r;
  logic                out_exh_r;
  logic                out_done_r;

  logic [WID_W-1:0]   wk;
  logic [WID_W-1:0]   cnt_addr;
  logic [CNT_W-1:0]   cnt_rd;
  logic [WORKERS-1:0] wk_onehot;
  logic [ADDR_W-1:0]  mem_base;
  logic [ADDR_W-1:0]  mem_addr;
  logic [TASK_W-1:0]  mem_rdata;
  logic               out_free;

  assign wk        = WID_W'(item_worker_r);
  assign wk_onehot = WORKERS'(1) << wk;
  assign out_free  = !out_valid_r || !out_stall;

  // capture accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode_r   <= in_mode;
      item_worker_r <= in_worker;
      item_x_r      <= in_tile_x;
      item_y_r      <= in_tile_y;
      item_acc_r    <= in_accum_id;
    end
  end

  // single count port, address picked by the sequencer
  always_comb begin
    case (cmd.cnt_sel)
      CS_ITEM: cnt_addr = wk;
      CS_SCAN: cnt_addr = scan_idx_r;
      CS_SRC:  cnt_addr = src_r;
      default: cnt_addr = wk;
    endcase
  end

  assign cnt_rd = cnt_r[cnt_addr];

  // count update on push and pop
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.do_push) begin
      cnt_nxt[cnt_addr] = CNT_W'(cnt_rd + 1'b1);
    end else if (cmd.rd_pop) begin
      cnt_nxt[cnt_addr] = CNT_W'(cnt_rd - 1'b1);
    end
  end

  // exhausted flags
  always_comb begin
    told_nxt = told_r;
    if (cmd.do_clear) begin
      told_nxt = '0;
    end else if (cmd.out_exh) begin
      told_nxt = told_r | wk_onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORKERS; i++) begin
        cnt_r[i] <= '0;
      end
      told_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      told_r <= told_nxt;
    end
  end

  // largest-stack scan and pop source
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      best_idx_r <= '0;
      best_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= WID_W'(scan_idx_r + 1'b1);
      if (cnt_rd > best_cnt_r) begin
        best_idx_r <= scan_idx_r;
        best_cnt_r <= cnt_rd;
      end
    end
    if (cmd.src_own) begin
      src_r <= wk;
    end else if (cmd.src_best) begin
      src_r <= best_idx_r;
    end
  end

  // stack memory address: stack base plus slot
  assign mem_base = ADDR_W'(cnt_addr) * ADDR_W'(STACK_DEPTH);
  assign mem_addr = cmd.do_push ? ADDR_W'(mem_base + ADDR_W'(cnt_rd))
                                : ADDR_W'(mem_base + ADDR_W'(cnt_rd) - 1'b1);

  tws_ram #(
    .WIDTH (TASK_W),
    .DEPTH (MEM_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.do_push),
    .waddr (mem_addr),
    .wdata ({item_x_r, item_y_r, item_acc_r}),
    .re    (cmd.rd_pop),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_task || cmd.out_exh) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_task) begin
      out_dest_r <= item_worker_r;
      out_x_r    <= mem_rdata[TASK_W-1 -: TILE_W];
      out_y_r    <= mem_rdata[ACCUM_W +: TILE_W];
      out_acc_r  <= mem_rdata[ACCUM_W-1:0];
      out_exh_r  <= 1'b0;
      out_done_r <= 1'b0;
    end else if (cmd.out_exh) begin
      out_dest_r <= item_worker_r;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_acc_r  <= '0;
      out_exh_r  <= 1'b1;
      out_done_r <= &(told_r | wk_onehot);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dest_worker = out_dest_r;
  assign out_task_x      = out_x_r;
  assign out_task_y      = out_y_r;
  assign out_task_accum  = out_acc_r;
  assign out_exhausted   = out_exh_r;
  assign out_frame_done  = out_done_r;

  // status to the sequencer
  assign stat.mode       = mode_t'(item_mode_r);
  assign stat.worker_ok  = (32'(item_worker_r) < WORKERS);
  assign stat.full       = (cnt_rd == CNT_W'(STACK_DEPTH));
  assign stat.told       = told_r[wk];
  assign stat.own_empty  = (cnt_rd == '0);
  assign stat.scan_last  = (scan_idx_r == WID_W'(WORKERS - 1));
  assign stat.best_empty = (best_cnt_r == '0);
  assign stat.out_free   = out_free;

  // checks
  `ASSERT_NEVER(a_push_pop, clk, rst_n, cmd.do_push && cmd.rd_pop, "push and pop together")
  `ASSERT_CLK(a_push_room, clk, rst_n, cmd.do_push |-> !stat.full, "push into full stack")
  `ASSERT_CLK(a_pop_nonempty, clk, rst_n, cmd.rd_pop |-> (cnt_rd != '0), "pop from empty stack")
  `ASSERT_NEVER(a_done_exh, clk, rst_n, out_valid_r && out_done_r && !out_exh_r, "stray done")

endmodule
